FILE: src/ltrr_pkg.sv
// Package for the lock table revoke/retry unit.
// Holds the item types, the lock mode, status and notice codes, and the default sizes.
// Depends on nothing; ltrr_decide and the top level use it.
package ltrr_pkg;

  localparam int LOCK_COUNT_DEF   = 256;
  localparam int CLIENT_COUNT_DEF = 16;

  localparam int INDEX_W  = 8;
  localparam int CLIENT_W = 4;
  localparam int MODE_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE     = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_WAITING  = 2'd2,
    MODE_RETRYING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RETRY = 2'd1,
    ST_IOERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    NOTE_NONE   = 2'd0,
    NOTE_REVOKE = 2'd1,
    NOTE_RETRY  = 2'd2
  } note_t;

  typedef enum logic {
    ACT_ACQUIRE = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [INDEX_W-1:0]   lock_index;
    logic [CLIENT_W-1:0]  client;
  } req_t;

  typedef struct packed {
    status_t              status;
    note_t                notify_kind;
    logic [CLIENT_W-1:0]  notify_client;
  } rsp_t;

endpackage

FILE: src/ltrr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the lock table of the lock table revoke/retry unit; no package dependency.
module ltrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/ltrr_decide.sv
// Next-entry and result logic for one request against one lock table entry.
// Purely combinational; depends on ltrr_pkg for item types and codes.
module ltrr_decide #(
  parameter int LOCK_COUNT   = ltrr_pkg::LOCK_COUNT_DEF,
  parameter int CLIENT_COUNT = ltrr_pkg::CLIENT_COUNT_DEF
) (
  input  ltrr_pkg::req_t                   req,
  input  ltrr_pkg::mode_t                  mode,
  input  logic [ltrr_pkg::CLIENT_W-1:0]    owner,
  input  logic [CLIENT_COUNT-1:0]          mask,
  output logic                             wr_en,
  output ltrr_pkg::mode_t                  mode_next,
  output logic [ltrr_pkg::CLIENT_W-1:0]    owner_next,
  output logic [CLIENT_COUNT-1:0]          mask_next,
  output ltrr_pkg::rsp_t                   rsp
);

  logic                          in_range;
  logic                          is_owner;
  logic [CLIENT_COUNT-1:0]       client_bit;
  logic [CLIENT_COUNT-1:0]       mask_less;
  logic [ltrr_pkg::CLIENT_W-1:0] lowest;

  always_comb begin
    for (int i = 0; i < CLIENT_COUNT; i++) begin
      client_bit[i] = ({28'd0, req.client} == 32'(i));
    end
  end

  // Lowest-numbered waiter, as a priority encoder.
  always_comb begin
    lowest = '0;
    for (int i = CLIENT_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        lowest = ltrr_pkg::CLIENT_W'(i);
      end
    end
  end

  assign in_range  = ({24'd0, req.lock_index} < 32'(LOCK_COUNT)) &&
                     ({28'd0, req.client} < 32'(CLIENT_COUNT));
  assign is_owner  = (owner == req.client);
  assign mask_less = mask & ~client_bit;

  always_comb begin
    wr_en             = in_range;
    mode_next         = mode;
    owner_next        = owner;
    mask_next         = mask;
    rsp.status        = ltrr_pkg::ST_OK;
    rsp.notify_kind   = ltrr_pkg::NOTE_NONE;
    rsp.notify_client = '0;
    if (!in_range) begin
      rsp.status = ltrr_pkg::ST_IOERR;
    end else if (req.action == ltrr_pkg::ACT_ACQUIRE) begin
      unique case (mode)
        ltrr_pkg::MODE_FREE: begin
          mode_next  = ltrr_pkg::MODE_LOCKED;
          owner_next = req.client;
        end
        ltrr_pkg::MODE_LOCKED: begin
          if (!is_owner) begin
            mode_next         = ltrr_pkg::MODE_WAITING;
            mask_next         = mask | client_bit;
            rsp.status        = ltrr_pkg::ST_RETRY;
            rsp.notify_kind   = ltrr_pkg::NOTE_REVOKE;
            rsp.notify_client = owner;
          end
        end
        ltrr_pkg::MODE_WAITING: begin
          if (!is_owner) begin
            mask_next  = mask | client_bit;
            rsp.status = ltrr_pkg::ST_RETRY;
          end
        end
        ltrr_pkg::MODE_RETRYING: begin
          if ((mask & client_bit) != '0) begin
            mask_next  = mask_less;
            owner_next = req.client;
            if (mask_less != '0) begin
              mode_next         = ltrr_pkg::MODE_WAITING;
              rsp.notify_kind   = ltrr_pkg::NOTE_REVOKE;
              rsp.notify_client = req.client;
            end else begin
              mode_next = ltrr_pkg::MODE_LOCKED;
            end
          end else begin
            mask_next  = mask | client_bit;
            rsp.status = ltrr_pkg::ST_RETRY;
          end
        end
        default: begin
          rsp.status = ltrr_pkg::ST_IOERR;
        end
      endcase
    end else begin
      unique case (mode)
        ltrr_pkg::MODE_LOCKED: begin
          if (is_owner) begin
            mode_next  = ltrr_pkg::MODE_FREE;
            owner_next = '0;
          end
        end
        ltrr_pkg::MODE_WAITING: begin
          if (is_owner) begin
            owner_next = '0;
            if (mask != '0) begin
              mode_next         = ltrr_pkg::MODE_RETRYING;
              rsp.notify_kind   = ltrr_pkg::NOTE_RETRY;
              rsp.notify_client = lowest;
            end else begin
              mode_next = ltrr_pkg::MODE_FREE;
            end
          end
        end
        default: begin
          rsp.status = ltrr_pkg::ST_IOERR;
        end
      endcase
    end
  end

endmodule

FILE: src/lock_table_revoke_retry_unit.sv
// Top level of the lock table revoke/retry unit: request register, table RAM with
// forwarding, decision logic and result register. Depends on ltrr_pkg, ltrr_ram, ltrr_decide.
//
// Usage. The req channel carries one item per acquire or release: action, lock_index
// and client. The rsp channel returns exactly one item per request: a status (OK,
// RETRY or IOERR) and an optional revoke or retry notice with the client it is for.
// Both channels use valid/stall; an item moves on a rising edge with valid high and
// stall low.
// Timing. A request's table entry is read at the edge that accepts it, and its result
// is registered in the result register when the request stage moves on, which sets
// rsp_valid. One request is taken every cycle while req_stall is low: the table is read
// once and written at most once per request, and a request that follows straight on
// one to the same lock takes its entry from a forwarding register instead of the RAM.
// Reset. After rst the unit sweeps the table, clearing one entry per cycle, so it
// holds req_stall high until the last entry is cleared before it takes its first request.
// Stalls. When rsp_stall holds a waiting result, the request stage holds as well and
// req_stall is raised; nothing is lost or repeated.
module lock_table_revoke_retry_unit #(
  parameter int LOCK_COUNT   = ltrr_pkg::LOCK_COUNT_DEF,
  parameter int CLIENT_COUNT = ltrr_pkg::CLIENT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ltrr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ltrr_pkg::rsp_t rsp
);

  localparam int IDX_W   = $clog2(LOCK_COUNT);
  localparam int ENTRY_W = ltrr_pkg::MODE_W + ltrr_pkg::CLIENT_W + CLIENT_COUNT;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_COUNT - 1);

  // Clearing sweep.
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  // Request stage.
  logic             s1_valid;
  ltrr_pkg::req_t   s1_req;
  logic [IDX_W-1:0] s1_idx;

  // Forwarding register: the last entry written to the table.
  logic               fwd_valid;
  logic [IDX_W-1:0]   fwd_idx;
  logic [ENTRY_W-1:0] fwd_data;

  logic               advance;
  logic               accept;
  logic [IDX_W-1:0]   req_idx;
  logic [31:0]        req_idx_wide;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  logic                          dec_we;
  ltrr_pkg::mode_t               mode_next;
  logic [ltrr_pkg::CLIENT_W-1:0] owner_next;
  logic [CLIENT_COUNT-1:0]       mask_next;
  ltrr_pkg::rsp_t                dec_rsp;

  // The request stage moves on whenever the result register is empty or is being taken.
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = clearing || !advance;
  assign accept    = req_valid && !req_stall;

  assign req_idx_wide = {24'd0, req.lock_index};
  assign req_idx      = req_idx_wide[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
      s1_idx <= req_idx;
    end
  end

  ltrr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOCK_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (req_idx),
    .rd_data (rd_data)
  );

  // The read was issued in the same cycle as the previous request's write, so that
  // write is taken from the forwarding register when the lock matches.
  assign entry = (fwd_valid && (fwd_idx == s1_idx)) ? fwd_data : rd_data;

  ltrr_decide #(
    .LOCK_COUNT   (LOCK_COUNT),
    .CLIENT_COUNT (CLIENT_COUNT)
  ) u_decide (
    .req        (s1_req),
    .mode       (ltrr_pkg::mode_t'(entry[ENTRY_W-1 -: ltrr_pkg::MODE_W])),
    .owner      (entry[CLIENT_COUNT +: ltrr_pkg::CLIENT_W]),
    .mask       (entry[CLIENT_COUNT-1:0]),
    .wr_en      (dec_we),
    .mode_next  (mode_next),
    .owner_next (owner_next),
    .mask_next  (mask_next),
    .rsp        (dec_rsp)
  );

  // During the sweep no request is in flight, so the write port belongs to it alone.
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid && advance && dec_we;
      ram_waddr = s1_idx;
      ram_wdata = {mode_next, owner_next, mask_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_idx  <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp <= dec_rsp;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> req_stall)
    else $error("request accepted during table clearing");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (clearing || (s1_valid && advance)))
    else $error("table written without a request moving on");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> rsp_valid)
    else $error("request stage moved on but no result was registered");

  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_idx) == LAST_IDX))
    else $error("table clearing ended before the last entry");

  a_quiet_notice: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.notify_kind == ltrr_pkg::NOTE_NONE)) |-> (rsp.notify_client == '0))
    else $error("notice client set without a notice");
`endif

endmodule
